// File: hw/rtl/led_cps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package led_cps_pkg;

    localparam int unsigned SLOT_W      = 6;
    localparam int unsigned COLOR_W     = 8;
    localparam int unsigned HOLD_IN_W   = 24;
    localparam int unsigned PASS_W      = 7;
    localparam int unsigned PHASE_W     = 3;
    localparam int unsigned CUR_W       = 6;
    localparam int unsigned OPCODE_W    = 2;
    localparam int unsigned S_TDATA_W   = 56;
    localparam int unsigned M_TDATA_W   = 40;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } t_opcode;

    typedef enum logic [PHASE_W-1:0] {
        PH_START    = 3'd0,
        PH_WAIT     = 3'd1,
        PH_WRITE    = 3'd2,
        PH_STOPPING = 3'd3,
        PH_STOPPED  = 3'd4
    } t_phase;

    localparam logic [CFG_INDEX_W-1:0] CFG_PLAY_MODE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PASS_COUNT = 1'b1;

    localparam logic PLAY_LOOP = 1'b0;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_color;

    typedef struct packed {
        logic             strip_update;
        t_color           color;
        t_phase           phase;
        logic [CUR_W-1:0] current_point;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/led_cps_table.sv
`timescale 1ns / 1ps
`default_nettype none

module led_cps_table #(
    parameter int unsigned MAX_POINTS = 64,
    parameter int unsigned HOLD_BITS  = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_wr_en,
    input  wire logic [$clog2(MAX_POINTS)-1:0]  i_wr_addr,
    input  wire led_cps_pkg::t_color            i_wr_color,
    input  wire logic [HOLD_BITS-1:0]           i_wr_hold,
    input  wire logic                           i_wr_end,
    input  wire logic [$clog2(MAX_POINTS)-1:0]  i_rd_addr,
    output led_cps_pkg::t_color                 o_rd_color,
    output logic [HOLD_BITS-1:0]                o_rd_hold,
    output logic                                o_rd_end
);

    localparam int unsigned ENTRY_W = $bits(led_cps_pkg::t_color) + HOLD_BITS + 1;

    logic [ENTRY_W-1:0] r_mem [MAX_POINTS];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [ENTRY_W-1:0] w_wr_data;

    assign w_wr_data = {i_wr_end, i_wr_hold, i_wr_color};

    // The read port follows the point index; a write to the same slot is
    // forwarded so the registered word always matches the table contents.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= w_wr_data;
        end
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= w_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_color = r_rd_data[$bits(led_cps_pkg::t_color)-1:0];
    assign o_rd_hold  = r_rd_data[ENTRY_W-2:$bits(led_cps_pkg::t_color)];
    assign o_rd_end   = r_rd_data[ENTRY_W-1];

endmodule

`default_nettype wire

// File: hw/rtl/led_cps_step.sv
`timescale 1ns / 1ps
`default_nettype none

module led_cps_step #(
    parameter int unsigned MAX_POINTS = 64,
    parameter int unsigned HOLD_BITS  = 24
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_accept,
    input  wire led_cps_pkg::t_opcode                  i_opcode,
    input  wire logic [led_cps_pkg::SLOT_W-1:0]        i_slot,
    input  wire led_cps_pkg::t_color                   i_color,
    input  wire logic [led_cps_pkg::HOLD_IN_W-1:0]     i_hold,
    input  wire logic                                  i_end,
    input  wire logic                                  i_play_mode,
    input  wire logic [led_cps_pkg::PASS_W-1:0]        i_pass_count,
    input  wire led_cps_pkg::t_color                   i_cur_color,
    input  wire logic [HOLD_BITS-1:0]                  i_cur_hold,
    input  wire logic                                  i_cur_end,
    output logic [$clog2(MAX_POINTS)-1:0]              o_rd_addr,
    output logic                                       o_wr_en,
    output logic [$clog2(MAX_POINTS)-1:0]              o_wr_addr,
    output led_cps_pkg::t_color                        o_wr_color,
    output logic [HOLD_BITS-1:0]                       o_wr_hold,
    output logic                                       o_wr_end,
    output led_cps_pkg::t_result                       o_result
);

    localparam int unsigned IDX_W    = $clog2(MAX_POINTS);
    localparam int unsigned SLOT_X_W = IDX_W + led_cps_pkg::SLOT_W;
    localparam int unsigned HOLD_X_W = HOLD_BITS + led_cps_pkg::HOLD_IN_W;
    localparam int unsigned CUR_X_W  = IDX_W + led_cps_pkg::CUR_W;

    led_cps_pkg::t_phase                 r_phase;
    led_cps_pkg::t_phase                 n_phase;
    logic [IDX_W-1:0]                    r_idx;
    logic [IDX_W-1:0]                    n_idx;
    logic [HOLD_BITS-1:0]                r_elapsed;
    logic [HOLD_BITS-1:0]                n_elapsed;
    logic [led_cps_pkg::PASS_W-1:0]      r_passes;
    logic [led_cps_pkg::PASS_W-1:0]      n_passes;
    led_cps_pkg::t_color                 r_row0;
    led_cps_pkg::t_color                 n_row0;

    logic [SLOT_X_W-1:0]                 w_slot_x;
    logic                                w_slot_ok;
    logic [HOLD_X_W-1:0]                 w_hold_x;
    logic [HOLD_BITS-1:0]                w_hold_sat;
    logic [HOLD_BITS-1:0]                w_elapsed_inc;
    logic [IDX_W-1:0]                    w_idx_next;
    logic [CUR_X_W-1:0]                  w_cur_x;
    logic                                w_update;
    led_cps_pkg::t_color                 w_out_color;

    assign w_slot_x   = {{IDX_W{1'b0}}, i_slot};
    assign w_slot_ok  = (w_slot_x < SLOT_X_W'(MAX_POINTS));
    assign w_hold_x   = {{HOLD_BITS{1'b0}}, i_hold};
    assign w_hold_sat = (|(w_hold_x >> HOLD_BITS)) ? {HOLD_BITS{1'b1}}
                                                   : w_hold_x[HOLD_BITS-1:0];
    assign w_elapsed_inc = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;
    assign w_idx_next    = (r_idx == IDX_W'(MAX_POINTS - 1)) ? '0 : r_idx + 1'b1;

    assign o_wr_en    = i_accept && (i_opcode == led_cps_pkg::OP_LOAD) && w_slot_ok;
    assign o_wr_addr  = w_slot_x[IDX_W-1:0];
    assign o_wr_color = i_color;
    assign o_wr_hold  = w_hold_sat;
    assign o_wr_end   = i_end;

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_elapsed   = r_elapsed;
        n_passes    = r_passes;
        n_row0      = r_row0;
        w_update    = 1'b0;
        w_out_color = '0;
        if (i_accept) begin
            unique case (i_opcode)
                led_cps_pkg::OP_LOAD: begin
                    if (o_wr_en && (o_wr_addr == '0)) begin
                        n_row0 = i_color;
                    end
                end
                led_cps_pkg::OP_START: begin
                    n_idx   = '0;
                    n_phase = led_cps_pkg::PH_START;
                end
                led_cps_pkg::OP_STOP: begin
                    n_phase = led_cps_pkg::PH_STOPPING;
                end
                led_cps_pkg::OP_TICK: begin
                    unique case (r_phase)
                        led_cps_pkg::PH_START: begin
                            w_update    = 1'b1;
                            w_out_color = i_cur_color;
                            n_passes    = i_pass_count;
                            n_elapsed   = '0;
                            n_phase     = led_cps_pkg::PH_WAIT;
                        end
                        led_cps_pkg::PH_WAIT: begin
                            n_elapsed = w_elapsed_inc;
                            if (!i_cur_end && (w_elapsed_inc >= i_cur_hold)) begin
                                n_elapsed = '0;
                                n_idx     = w_idx_next;
                                n_phase   = led_cps_pkg::PH_WRITE;
                            end
                        end
                        led_cps_pkg::PH_WRITE: begin
                            if (i_cur_end) begin
                                n_idx = '0;
                                if (i_play_mode == led_cps_pkg::PLAY_LOOP) begin
                                    w_update    = 1'b1;
                                    w_out_color = r_row0;
                                    n_phase     = led_cps_pkg::PH_WAIT;
                                end else if (r_passes > led_cps_pkg::PASS_W'(1)) begin
                                    n_passes    = r_passes - 1'b1;
                                    w_update    = 1'b1;
                                    w_out_color = r_row0;
                                    n_phase     = led_cps_pkg::PH_WAIT;
                                end else begin
                                    n_passes = '0;
                                    n_phase  = led_cps_pkg::PH_STOPPING;
                                end
                            end else begin
                                w_update    = 1'b1;
                                w_out_color = i_cur_color;
                                n_phase     = led_cps_pkg::PH_WAIT;
                            end
                        end
                        led_cps_pkg::PH_STOPPING: begin
                            w_update = 1'b1;
                            n_idx    = '0;
                            n_phase  = led_cps_pkg::PH_STOPPED;
                        end
                        default: begin
                            n_phase = led_cps_pkg::PH_STOPPED;
                        end
                    endcase
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    assign w_cur_x   = {{led_cps_pkg::CUR_W{1'b0}}, n_idx};
    assign o_rd_addr = n_idx;

    always_comb begin
        o_result.strip_update  = w_update;
        o_result.color         = w_out_color;
        o_result.phase         = n_phase;
        o_result.current_point = w_cur_x[led_cps_pkg::CUR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= led_cps_pkg::PH_STOPPED;
            r_idx     <= '0;
            r_elapsed <= '0;
            r_passes  <= '0;
        end else begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_elapsed <= n_elapsed;
            r_passes  <= n_passes;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row0 <= n_row0;
    end

endmodule

`default_nettype wire

// File: hw/rtl/led_cps_skid.sv
`timescale 1ns / 1ps
`default_nettype none

module led_cps_skid (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire led_cps_pkg::t_result  i_data,
    output logic                       o_ready,
    output logic                       o_valid,
    output led_cps_pkg::t_result       o_data,
    input  wire logic                  i_ready
);

    logic                  r_out_valid;
    led_cps_pkg::t_result  r_out_data;
    logic                  r_skid_valid;
    led_cps_pkg::t_result  r_skid_data;
    logic                  w_out_fire;

    assign w_out_fire = r_out_valid && i_ready;
    assign o_ready    = i_rst_n && !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (w_out_fire) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (i_valid) begin
                if (!r_out_valid || w_out_fire) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (w_out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_valid) begin
            if (!r_out_valid || w_out_fire) begin
                r_out_data <= i_data;
            end else begin
                r_skid_data <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/led_color_point_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// s         in         i_s_tvalid / o_s_tready    i_s_tdata, i_s_tuser (one command word)
// m         out        o_m_tvalid / i_m_tready    o_m_tdata, o_m_tuser (one result word)
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Every accepted word produces exactly one result word; one word per cycle is sustained
// while i_m_tready is high; the phase, index and hold counter registers update per word.
// The point table is a one-write, one-read memory whose read port tracks the point index.
// Reset sets the phase to stopped and clears the index and counters; the table is not cleared.
// Both ready outputs are low during reset.
// Outside reset, o_s_tready is low only while the output and skid registers both hold words.

module led_color_point_sequencer_core #(
    parameter int unsigned MAX_POINTS = 64,
    parameter int unsigned HOLD_BITS  = 24
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_s_tvalid,
    output logic                                         o_s_tready,
    // point_slot[5:0], load_red[13:6], load_green[21:14], load_blue[29:22],
    // hold_ms[53:30], end_marker[54], zero[55]
    input  wire logic [led_cps_pkg::S_TDATA_W-1:0]       i_s_tdata,
    // opcode[1:0]
    input  wire logic [led_cps_pkg::OPCODE_W-1:0]        i_s_tuser,
    output logic                                         o_m_tvalid,
    input  wire logic                                    i_m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16], play_phase[26:24],
    // current_point[32:27], zero[39:33]
    output logic [led_cps_pkg::M_TDATA_W-1:0]            o_m_tdata,
    // strip_update[0]
    output logic                                         o_m_tuser,
    input  wire logic                                    i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  wire logic [led_cps_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [led_cps_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int unsigned IDX_W = $clog2(MAX_POINTS);

    logic                                r_play_mode;
    logic [led_cps_pkg::PASS_W-1:0]      r_pass_count;

    logic                                w_accept;
    led_cps_pkg::t_opcode                w_opcode;
    led_cps_pkg::t_color                 w_in_color;
    logic [IDX_W-1:0]                    w_rd_addr;
    logic                                w_wr_en;
    logic [IDX_W-1:0]                    w_wr_addr;
    led_cps_pkg::t_color                 w_wr_color;
    logic [HOLD_BITS-1:0]                w_wr_hold;
    logic                                w_wr_end;
    led_cps_pkg::t_color                 w_cur_color;
    logic [HOLD_BITS-1:0]                w_cur_hold;
    logic                                w_cur_end;
    led_cps_pkg::t_result                w_result;
    led_cps_pkg::t_result                w_out;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play_mode  <= 1'b0;
            r_pass_count <= led_cps_pkg::PASS_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                led_cps_pkg::CFG_PLAY_MODE:  r_play_mode  <= i_cfg_data[0];
                led_cps_pkg::CFG_PASS_COUNT: r_pass_count <= i_cfg_data;
                default: begin
                    r_play_mode <= r_play_mode;
                end
            endcase
        end
    end

    assign w_accept         = i_s_tvalid && o_s_tready;
    assign w_opcode         = led_cps_pkg::t_opcode'(i_s_tuser);
    assign w_in_color.red   = i_s_tdata[13:6];
    assign w_in_color.green = i_s_tdata[21:14];
    assign w_in_color.blue  = i_s_tdata[29:22];

    led_cps_table #(
        .MAX_POINTS (MAX_POINTS),
        .HOLD_BITS  (HOLD_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_color (w_wr_color),
        .i_wr_hold  (w_wr_hold),
        .i_wr_end   (w_wr_end),
        .i_rd_addr  (w_rd_addr),
        .o_rd_color (w_cur_color),
        .o_rd_hold  (w_cur_hold),
        .o_rd_end   (w_cur_end)
    );

    led_cps_step #(
        .MAX_POINTS (MAX_POINTS),
        .HOLD_BITS  (HOLD_BITS)
    ) u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_opcode     (w_opcode),
        .i_slot       (i_s_tdata[5:0]),
        .i_color      (w_in_color),
        .i_hold       (i_s_tdata[53:30]),
        .i_end        (i_s_tdata[54]),
        .i_play_mode  (r_play_mode),
        .i_pass_count (r_pass_count),
        .i_cur_color  (w_cur_color),
        .i_cur_hold   (w_cur_hold),
        .i_cur_end    (w_cur_end),
        .o_rd_addr    (w_rd_addr),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_color   (w_wr_color),
        .o_wr_hold    (w_wr_hold),
        .o_wr_end     (w_wr_end),
        .o_result     (w_result)
    );

    led_cps_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_data  (w_result),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .o_data  (w_out),
        .i_ready (i_m_tready)
    );

    assign o_m_tuser = w_out.strip_update;
    assign o_m_tdata = {7'd0, w_out.current_point, w_out.phase,
                        w_out.color.blue, w_out.color.green, w_out.color.red};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("skid register full while output register empty");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_result.strip_update |-> (w_result.color == '0))
        else $error("color driven without a strip update");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_opcode == led_cps_pkg::OP_STOP))
            |-> (w_result.phase == led_cps_pkg::PH_STOPPING) && !w_result.strip_update)
        else $error("stop word did not enter the stopping phase");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_opcode == led_cps_pkg::OP_START))
            |-> (w_result.phase == led_cps_pkg::PH_START)
                && (w_result.current_point == '0) && !w_result.strip_update)
        else $error("start word did not enter the start phase");

endmodule

`default_nettype wire

// File: verif/led_color_point_sequencer_core_tb.sv
`timescale 1ns / 1ps

module led_color_point_sequencer_core_tb;

    localparam int unsigned TABLE_SLOTS = 64;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_WORDS = 80;
    localparam int unsigned PHASES = 5;

    typedef struct {
        led_cps_pkg::t_opcode                   op;
        logic [led_cps_pkg::SLOT_W-1:0]         slot;
        logic [led_cps_pkg::COLOR_W-1:0]        red;
        logic [led_cps_pkg::COLOR_W-1:0]        green;
        logic [led_cps_pkg::COLOR_W-1:0]        blue;
        logic [led_cps_pkg::HOLD_IN_W-1:0]      hold;
        logic                                   end_mark;
    } t_seq_cmd;

    class t_strip_scoreboard;
        led_cps_pkg::t_result                   expected_frames[$];
        int                                     failures;
        led_cps_pkg::t_phase                    phase;
        logic [led_cps_pkg::SLOT_W-1:0]         index;
        logic [led_cps_pkg::HOLD_IN_W-1:0]      elapsed;
        logic [led_cps_pkg::PASS_W-1:0]         passes_left;
        logic                                   play_mode;
        logic [led_cps_pkg::PASS_W-1:0]         pass_count;
        logic [led_cps_pkg::COLOR_W-1:0]        pt_red[TABLE_SLOTS];
        logic [led_cps_pkg::COLOR_W-1:0]        pt_green[TABLE_SLOTS];
        logic [led_cps_pkg::COLOR_W-1:0]        pt_blue[TABLE_SLOTS];
        logic [led_cps_pkg::HOLD_IN_W-1:0]      pt_hold[TABLE_SLOTS];
        logic                                   pt_end[TABLE_SLOTS];

        function void reset_state();
            phase = led_cps_pkg::PH_STOPPED;
            index = '0;
            elapsed = '0;
            passes_left = '0;
            play_mode = led_cps_pkg::PLAY_LOOP;
            pass_count = led_cps_pkg::PASS_W'(1);
            failures = 0;
        endfunction

        function void set_register(logic [led_cps_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [led_cps_pkg::CFG_DATA_W-1:0] data);
            if (idx == led_cps_pkg::CFG_PLAY_MODE) begin
                play_mode = data[0];
            end else begin
                pass_count = data;
            end
        endfunction

        function led_cps_pkg::t_color point_color(logic [led_cps_pkg::SLOT_W-1:0] idx);
            led_cps_pkg::t_color c;
            c.red = pt_red[idx];
            c.green = pt_green[idx];
            c.blue = pt_blue[idx];
            return c;
        endfunction

        function void note_command(t_seq_cmd c);
            led_cps_pkg::t_result r;
            r = '0;
            case (c.op)
                led_cps_pkg::OP_LOAD: begin
                    pt_red[c.slot] = c.red;
                    pt_green[c.slot] = c.green;
                    pt_blue[c.slot] = c.blue;
                    pt_hold[c.slot] = c.hold;
                    pt_end[c.slot] = c.end_mark;
                end
                led_cps_pkg::OP_START: begin
                    index = '0;
                    phase = led_cps_pkg::PH_START;
                end
                led_cps_pkg::OP_STOP: begin
                    phase = led_cps_pkg::PH_STOPPING;
                end
                default: begin
                    case (phase)
                        led_cps_pkg::PH_START: begin
                            r.strip_update = 1'b1;
                            r.color = point_color(index);
                            passes_left = pass_count;
                            elapsed = '0;
                            phase = led_cps_pkg::PH_WAIT;
                        end
                        led_cps_pkg::PH_WAIT: begin
                            if (elapsed != '1) begin
                                elapsed = elapsed + 1'b1;
                            end
                            if (!pt_end[index] && elapsed >= pt_hold[index]) begin
                                elapsed = '0;
                                index = index + 1'b1;
                                phase = led_cps_pkg::PH_WRITE;
                            end
                        end
                        led_cps_pkg::PH_WRITE: begin
                            if (pt_end[index]) begin
                                index = '0;
                                if (play_mode == led_cps_pkg::PLAY_LOOP
                                        || passes_left > led_cps_pkg::PASS_W'(1)) begin
                                    if (play_mode != led_cps_pkg::PLAY_LOOP) begin
                                        passes_left = passes_left - 1'b1;
                                    end
                                    r.strip_update = 1'b1;
                                    r.color = point_color('0);
                                    phase = led_cps_pkg::PH_WAIT;
                                end else begin
                                    passes_left = '0;
                                    phase = led_cps_pkg::PH_STOPPING;
                                end
                            end else begin
                                r.strip_update = 1'b1;
                                r.color = point_color(index);
                                phase = led_cps_pkg::PH_WAIT;
                            end
                        end
                        led_cps_pkg::PH_STOPPING: begin
                            r.strip_update = 1'b1;
                            index = '0;
                            phase = led_cps_pkg::PH_STOPPED;
                        end
                        default: begin
                            phase = led_cps_pkg::PH_STOPPED;
                        end
                    endcase
                end
            endcase
            r.phase = phase;
            r.current_point = index;
            expected_frames.push_back(r);
        endfunction

        function void check_word(logic [led_cps_pkg::M_TDATA_W-1:0] tdata, logic tuser);
            led_cps_pkg::t_result got;
            led_cps_pkg::t_result want;
            got.strip_update = tuser;
            got.color.red = tdata[7:0];
            got.color.green = tdata[15:8];
            got.color.blue = tdata[23:16];
            got.phase = led_cps_pkg::t_phase'(tdata[26:24]);
            got.current_point = tdata[32:27];
            if (expected_frames.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected result word %h / %b", tdata, tuser);
                end
                return;
            end
            want = expected_frames.pop_front();
            if (got.strip_update !== want.strip_update || got.color.red !== want.color.red
                    || got.color.green !== want.color.green
                    || got.color.blue !== want.color.blue || got.phase !== want.phase
                    || got.current_point !== want.current_point) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch: expected upd=%b rgb=%h/%h/%h phase=%0d point=%0d",
                             want.strip_update, want.color.red, want.color.green,
                             want.color.blue, want.phase, want.current_point);
                    $display("          actual   upd=%b rgb=%h/%h/%h phase=%0d point=%0d",
                             got.strip_update, got.color.red, got.color.green,
                             got.color.blue, got.phase, got.current_point);
                end
            end
        endfunction
    endclass

    logic                                   clk;
    logic                                   rst_n;
    logic                                   s_tvalid;
    logic [led_cps_pkg::S_TDATA_W-1:0]      s_tdata;
    logic [led_cps_pkg::OPCODE_W-1:0]       s_tuser;
    logic                                   m_tready = 1'b0;
    logic                                   cfg_valid;
    logic [led_cps_pkg::CFG_INDEX_W-1:0]    cfg_index;
    logic [led_cps_pkg::CFG_DATA_W-1:0]     cfg_data;
    wire                                    s_tready;
    wire                                    m_tvalid;
    wire  [led_cps_pkg::M_TDATA_W-1:0]      m_tdata;
    wire                                    m_tuser;
    wire                                    cfg_ready;

    int unsigned                            idle_pct;
    int unsigned                            stall_pct;
    int unsigned                            cycles;
    t_strip_scoreboard                      sb;

    led_color_point_sequencer_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(negedge clk) begin
        m_tready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid === 1'b1 && m_tready) begin
            sb.check_word(m_tdata, m_tuser);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("led_color_point_sequencer_core test failed");
            $finish;
        end
    end

    function automatic t_seq_cmd make_load(logic [led_cps_pkg::SLOT_W-1:0] slot,
                                           logic [led_cps_pkg::COLOR_W-1:0] red,
                                           logic [led_cps_pkg::COLOR_W-1:0] green,
                                           logic [led_cps_pkg::COLOR_W-1:0] blue,
                                           logic [led_cps_pkg::HOLD_IN_W-1:0] hold,
                                           logic end_mark);
        t_seq_cmd c;
        c.op = led_cps_pkg::OP_LOAD;
        c.slot = slot;
        c.red = red;
        c.green = green;
        c.blue = blue;
        c.hold = hold;
        c.end_mark = end_mark;
        return c;
    endfunction

    // Fields other than the opcode are ignored by ticks, starts and stops, so they carry noise.
    function automatic t_seq_cmd noise_word(led_cps_pkg::t_opcode op);
        t_seq_cmd c;
        c = make_load(led_cps_pkg::SLOT_W'($urandom), led_cps_pkg::COLOR_W'($urandom),
                      led_cps_pkg::COLOR_W'($urandom), led_cps_pkg::COLOR_W'($urandom),
                      led_cps_pkg::HOLD_IN_W'($urandom), 1'($urandom));
        c.op = op;
        return c;
    endfunction

    task automatic send_word(t_seq_cmd c);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = c.op;
        s_tdata = {1'b0, c.end_mark, c.hold, c.blue, c.green, c.red, c.slot};
        do @(posedge clk); while (s_tready !== 1'b1);
        sb.note_command(c);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.expected_frames.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic cfg_write(logic [led_cps_pkg::CFG_INDEX_W-1:0] idx,
                             logic [led_cps_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.set_register(idx, data);
    endtask

    task automatic directed_words();
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            send_word(make_load(led_cps_pkg::SLOT_W'(i), led_cps_pkg::COLOR_W'($urandom),
                                led_cps_pkg::COLOR_W'($urandom),
                                led_cps_pkg::COLOR_W'($urandom),
                                led_cps_pkg::HOLD_IN_W'(i % 4), i == TABLE_SLOTS - 1));
        end
        send_word(noise_word(led_cps_pkg::OP_TICK));
        send_word(make_load(led_cps_pkg::SLOT_W'(1), 8'hFF, 8'hFF, 8'hFF,
                            led_cps_pkg::HOLD_IN_W'(1), 1'b0));
        send_word(make_load(led_cps_pkg::SLOT_W'(2), 8'h00, 8'h00, 8'h00,
                            led_cps_pkg::HOLD_IN_W'(0), 1'b1));
        send_word(noise_word(led_cps_pkg::OP_START));
        repeat (8) send_word(noise_word(led_cps_pkg::OP_TICK));
        send_word(noise_word(led_cps_pkg::OP_STOP));
        repeat (2) send_word(noise_word(led_cps_pkg::OP_TICK));
        // A terminator in slot 0 holds playback on the first point until a command.
        send_word(make_load(led_cps_pkg::SLOT_W'(0), 8'h80, 8'h40, 8'h20, '1, 1'b1));
        send_word(noise_word(led_cps_pkg::OP_START));
        repeat (3) send_word(noise_word(led_cps_pkg::OP_TICK));
        send_word(noise_word(led_cps_pkg::OP_STOP));
        send_word(noise_word(led_cps_pkg::OP_TICK));
        send_word(make_load(led_cps_pkg::SLOT_W'(0), 8'h12, 8'h34, 8'h56,
                            led_cps_pkg::HOLD_IN_W'(0), 1'b0));
        send_word(noise_word(led_cps_pkg::OP_START));
        repeat (4) send_word(noise_word(led_cps_pkg::OP_TICK));
        send_word(noise_word(led_cps_pkg::OP_START));
        send_word(noise_word(led_cps_pkg::OP_TICK));
    endtask

    initial begin
        logic                                   modes[PHASES] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
        logic [led_cps_pkg::CFG_DATA_W-1:0]     passes[PHASES] = '{7'd0, 7'd0, 7'd2, 7'd127,
                                                                   7'd3};
        int unsigned                            idles[4] = '{0, 50, 0, 15};
        int unsigned                            stalls[4] = '{0, 0, 50, 15};
        int unsigned                            pick;
        int unsigned                            hsel;
        logic [led_cps_pkg::SLOT_W-1:0]         slot;
        logic [led_cps_pkg::HOLD_IN_W-1:0]      hold;
        t_seq_cmd                               c;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = led_cps_pkg::OP_TICK;
        cfg_valid = 1'b0;
        cfg_index = led_cps_pkg::CFG_PLAY_MODE;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        cycles = 0;
        sb = new;
        sb.reset_state();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            idle_pct = idles[ph % 4];
            stall_pct = stalls[ph % 4];
            cfg_write(led_cps_pkg::CFG_PLAY_MODE, led_cps_pkg::CFG_DATA_W'(modes[ph]));
            cfg_write(led_cps_pkg::CFG_PASS_COUNT, passes[ph]);
            @(negedge clk);
            cfg_valid = 1'b0;
            if (ph == 0) begin
                directed_words();
            end
            for (int n = 0; n < RANDOM_WORDS; n++) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    c = noise_word(led_cps_pkg::OP_TICK);
                end else if (pick < 88) begin
                    // Short lists in the low slots keep playback moving through terminators.
                    slot = ($urandom_range(9) < 7) ? led_cps_pkg::SLOT_W'($urandom_range(7))
                                                   : led_cps_pkg::SLOT_W'($urandom);
                    hsel = $urandom_range(99);
                    hold = (hsel < 85) ? led_cps_pkg::HOLD_IN_W'($urandom_range(4)) :
                           (hsel < 97) ? led_cps_pkg::HOLD_IN_W'($urandom_range(40)) :
                                         led_cps_pkg::HOLD_IN_W'($urandom);
                    c = make_load(slot, led_cps_pkg::COLOR_W'($urandom),
                                  led_cps_pkg::COLOR_W'($urandom),
                                  led_cps_pkg::COLOR_W'($urandom), hold,
                                  $urandom_range(99) < 15);
                end else if (pick < 95) begin
                    c = noise_word(led_cps_pkg::OP_START);
                end else begin
                    c = noise_word(led_cps_pkg::OP_STOP);
                end
                send_word(c);
                if (n == 40 || $urandom_range(99) == 0) begin
                    drain();
                end
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.expected_frames.size() == 0) begin
            $display("led_color_point_sequencer_core test passed");
        end else begin
            $display("led_color_point_sequencer_core test failed");
        end
        $finish;
    end

endmodule
